/* rtl/tce_pkg.sv */
// Shared types, codes and constants of the text console engine.
package tce_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int CELL_W     = 16;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int TAB_STEP   = 8;

    localparam logic [7:0]        ATTR_RESET  = 8'h07;
    localparam logic [7:0]        BLANK_CHAR  = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;

    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI  = 8'h7F;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_ATTRIBUTE = 2'd0,
        REG_CURSOR_ENABLE  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_col;
    } command_t;

    typedef struct packed {
        logic [4:0]        cursor_row_out;
        logic [6:0]        cursor_col_out;
        logic [10:0]       cursor_position;
        logic              cursor_update;
        logic [CELL_W-1:0] cell_value;
        logic              rejected;
        logic              scrolled;
    } result_t;

    // Requests from the command sequencer to the cell store.
    typedef struct packed {
        logic              fill;
        logic              scroll;
        logic              wr_en;
        logic              rd_en;
        logic [CELL_W-1:0] fill_value;
        logic [CELL_W-1:0] wr_data;
    } store_ctrl_t;

endpackage

/* rtl/tce_cell_store.sv */
// Screen cell memory with its fill and scroll-copy sweep engine.
module tce_cell_store #(
    parameter int COLUMNS = tce_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tce_pkg::DEFAULT_ROWS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tce_pkg::store_ctrl_t                 ctrl,
    input  logic [$clog2(ROWS*COLUMNS)-1:0]      wr_addr,
    input  logic [$clog2(ROWS*COLUMNS)-1:0]      rd_addr,
    output logic [tce_pkg::CELL_W-1:0]           rd_data,
    output logic                                 sweep_done
);
    import tce_pkg::*;

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int AW       = $clog2(CELLS);
    localparam int CNTW     = $clog2(CELLS + 1);
    localparam int COPY_LEN = CELLS - COLUMNS;

    logic [CELL_W-1:0] mem [CELLS];

    logic              active_reg;
    logic              scroll_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              copy_valid_reg;
    logic [AW-1:0]     copy_addr_reg;
    logic [CELL_W-1:0] fill_value_reg;
    logic [CELL_W-1:0] rd_data_reg;

    logic              last;
    logic              in_copy;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // A fill ends on the last cell; a scroll ends with the counter past the last cell, to drain the copy.
    assign last = scroll_reg ? (cnt_reg == CNTW'(CELLS)) : (cnt_reg == CNTW'(CELLS - 1));
    assign sweep_done = active_reg && last;
    assign in_copy = active_reg && scroll_reg && (int'(cnt_reg) < COPY_LEN);
    assign rd_data = rd_data_reg;

    always_comb
    begin
        mem_we    = ctrl.wr_en;
        mem_waddr = wr_addr;
        mem_wdata = ctrl.wr_data;
        if (copy_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_addr_reg;
            mem_wdata = rd_data_reg;
        end
        else if (active_reg && !scroll_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[AW-1:0];
            mem_wdata = fill_value_reg;
        end
        else if (active_reg && scroll_reg && (int'(cnt_reg) > COPY_LEN))
        begin
            // blank the bottom line, one cell behind the counter
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_reg - 1'b1);
            mem_wdata = fill_value_reg;
        end
    end

    always_comb
    begin
        if (in_copy)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(int'(cnt_reg) + COLUMNS);
        end
        else
        begin
            mem_re    = ctrl.rd_en;
            mem_raddr = rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            scroll_reg     <= 1'b0;
            cnt_reg        <= '0;
            copy_valid_reg <= 1'b0;
        end
        else
        begin
            copy_valid_reg <= in_copy;
            if (active_reg)
            begin
                if (last)
                    active_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (ctrl.fill || ctrl.scroll)
            begin
                active_reg <= 1'b1;
                scroll_reg <= ctrl.scroll;
                cnt_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!active_reg && (ctrl.fill || ctrl.scroll))
            fill_value_reg <= ctrl.fill_value;
        copy_addr_reg <= cnt_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    a_no_access_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !ctrl.wr_en && !ctrl.rd_en)
        else $error("single access issued while a sweep is running");

endmodule

/* rtl/text_console_engine.sv */
// Top level of the text console engine: command sequencer, cursor and configuration.
//
// One command is taken when start is high and busy is low; its result word appears on
// result for exactly one cycle with done high, and cannot be held off. Put character,
// set cursor and read cell pass through an execute state and a report state before done
// (a backspace that steps back adds a write state between them), and busy drops in the
// same cycle as done, so a new command may follow at once. Clear screen walks every cell
// of the store through its single write port; a put character that scrolls copies the
// store up one line with a read and a write each cycle. After reset the store is filled
// with blank grey cells while busy is high; configuration writes are taken during that
// time as ever.
module text_console_engine #(
    parameter int COLUMNS = tce_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tce_pkg::DEFAULT_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  tce_pkg::command_t                command,
    output logic                             done,
    output tce_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tce_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tce_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_EXEC,
        ST_BS_WRITE,
        ST_SWEEP_WAIT,
        ST_REPORT
    } state_t;

    state_t        state_reg;
    command_t      cmd_reg;
    logic [RW-1:0] cur_row_reg;
    logic [CW-1:0] cur_col_reg;
    logic          rej_reg;
    logic          scr_reg;
    logic          report_reg;
    logic          read_ok_reg;
    logic          done_reg;
    result_t       result_reg;
    logic [7:0]    attr_reg;
    logic          cursor_en_reg;

    logic [RW-1:0]     row_next;
    logic [CW-1:0]     col_next;
    logic              line_go;
    logic              scroll_go;
    logic              bs_go;
    logic              put_wr;
    logic              target_ok;
    logic              row_last;
    logic [CW:0]       col_inc;
    logic [CW:0]       tab_col;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     target_addr;
    logic [CELL_W-1:0] blank_cell;
    logic              is_print;
    logic              sweep_done;
    logic [CELL_W-1:0] rd_data;
    store_ctrl_t       store_ctrl;

    assign blank_cell  = {attr_reg, BLANK_CHAR};
    assign cur_addr    = AW'(int'(cur_row_reg) * COLUMNS + int'(cur_col_reg));
    assign target_ok   = (int'(cmd_reg.target_row) < ROWS) && (int'(cmd_reg.target_col) < COLUMNS);
    assign target_addr = AW'(int'(cmd_reg.target_row) * COLUMNS + int'(cmd_reg.target_col));
    assign row_last    = (cur_row_reg == RW'(ROWS - 1));
    assign col_inc     = (CW+1)'(cur_col_reg) + 1'b1;
    assign tab_col     = ((CW+1)'(cur_col_reg) + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
    assign is_print    = (cmd_reg.char_code >= CHAR_PRINT_LO) && (cmd_reg.char_code <= CHAR_PRINT_HI);

    // Work out the cursor move and side effects of the latched command.
    always_comb
    begin
        row_next  = cur_row_reg;
        col_next  = cur_col_reg;
        line_go   = 1'b0;
        scroll_go = 1'b0;
        bs_go     = 1'b0;
        put_wr    = 1'b0;
        unique case (cmd_reg.cmd)
            CMD_PUT:
            begin
                priority if (cmd_reg.char_code == CHAR_NEWLINE)
                    line_go = 1'b1;
                else if (cmd_reg.char_code == CHAR_RETURN)
                    col_next = '0;
                else if (cmd_reg.char_code == CHAR_TAB)
                begin
                    if (int'(tab_col) >= COLUMNS)
                        line_go = 1'b1;
                    else
                        col_next = tab_col[CW-1:0];
                end
                else if (cmd_reg.char_code == CHAR_BACKSPACE)
                begin
                    if (cur_col_reg != '0)
                    begin
                        col_next = cur_col_reg - 1'b1;
                        bs_go    = 1'b1;
                    end
                    else if (cur_row_reg != '0)
                    begin
                        row_next = cur_row_reg - 1'b1;
                        col_next = CW'(COLUMNS - 1);
                        bs_go    = 1'b1;
                    end
                end
                else if (is_print)
                begin
                    put_wr = 1'b1;
                    if (int'(col_inc) >= COLUMNS)
                        line_go = 1'b1;
                    else
                        col_next = col_inc[CW-1:0];
                end
                else
                begin
                    // other bytes leave the cursor where it is
                    col_next = cur_col_reg;
                end
            end
            CMD_CLEAR:
            begin
                row_next = '0;
                col_next = '0;
            end
            CMD_SET:
            begin
                if (target_ok)
                begin
                    row_next = cmd_reg.target_row[RW-1:0];
                    col_next = cmd_reg.target_col[CW-1:0];
                end
            end
            CMD_READ:
            begin
                row_next = cur_row_reg;
            end
            default:
            begin
                row_next = cur_row_reg;
            end
        endcase
        if (line_go)
        begin
            col_next = '0;
            if (row_last)
                scroll_go = 1'b1;
            else
                row_next = cur_row_reg + 1'b1;
        end
    end

    always_comb
    begin
        store_ctrl.fill       = (state_reg == ST_INIT)
                             || (state_reg == ST_EXEC && cmd_reg.cmd == CMD_CLEAR);
        store_ctrl.scroll     = (state_reg == ST_EXEC) && (cmd_reg.cmd == CMD_PUT) && scroll_go;
        store_ctrl.fill_value = (state_reg == ST_INIT) ? RESET_CELL : blank_cell;
        store_ctrl.wr_en      = ((state_reg == ST_EXEC) && (cmd_reg.cmd == CMD_PUT) && put_wr)
                             || (state_reg == ST_BS_WRITE);
        store_ctrl.wr_data    = (state_reg == ST_BS_WRITE) ? blank_cell
                                                           : {attr_reg, cmd_reg.char_code};
        store_ctrl.rd_en      = (state_reg == ST_EXEC) && (cmd_reg.cmd == CMD_READ) && target_ok;
    end

    tce_cell_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cell_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (store_ctrl),
        .wr_addr    (cur_addr),
        .rd_addr    (target_addr),
        .rd_data    (rd_data),
        .sweep_done (sweep_done)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            cursor_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEXT_ATTRIBUTE: attr_reg      <= cfg_data;
                REG_CURSOR_ENABLE:  cursor_en_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_INIT:
                    state_reg <= ST_INIT_WAIT;
                ST_INIT_WAIT:
                    if (sweep_done)
                        state_reg <= ST_IDLE;
                ST_IDLE:
                    if (start)
                    begin
                        cmd_reg   <= command;
                        state_reg <= ST_EXEC;
                    end
                ST_EXEC:
                begin
                    cur_row_reg <= row_next;
                    cur_col_reg <= col_next;
                    rej_reg     <= (cmd_reg.cmd == CMD_SET || cmd_reg.cmd == CMD_READ)
                                   && !target_ok;
                    scr_reg     <= (cmd_reg.cmd == CMD_PUT) && scroll_go;
                    report_reg  <= (cmd_reg.cmd == CMD_PUT) || (cmd_reg.cmd == CMD_CLEAR)
                                   || (cmd_reg.cmd == CMD_SET && target_ok);
                    read_ok_reg <= (cmd_reg.cmd == CMD_READ) && target_ok;
                    if (cmd_reg.cmd == CMD_CLEAR || store_ctrl.scroll)
                        state_reg <= ST_SWEEP_WAIT;
                    else if (cmd_reg.cmd == CMD_PUT && bs_go)
                        state_reg <= ST_BS_WRITE;
                    else
                        state_reg <= ST_REPORT;
                end
                ST_BS_WRITE:
                    state_reg <= ST_REPORT;
                ST_SWEEP_WAIT:
                    if (sweep_done)
                        state_reg <= ST_REPORT;
                ST_REPORT:
                begin
                    result_reg.cursor_row_out  <= 5'(cur_row_reg);
                    result_reg.cursor_col_out  <= 7'(cur_col_reg);
                    result_reg.cursor_position <= 11'(cur_addr);
                    result_reg.cursor_update   <= report_reg && cursor_en_reg;
                    result_reg.cell_value      <= read_ok_reg ? rd_data : '0;
                    result_reg.rejected        <= rej_reg;
                    result_reg.scrolled        <= scr_reg;
                    done_reg                   <= 1'b1;
                    state_reg                  <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_row_reg) < ROWS) && (int'(cur_col_reg) < COLUMNS))
        else $error("cursor outside the screen");

    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == ST_REPORT)
        else $error("result word without a report step");

    a_sweep_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_done |-> (state_reg == ST_INIT_WAIT) || (state_reg == ST_SWEEP_WAIT))
        else $error("sweep finished while nobody waits for it");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.scrolled |-> (cur_row_reg == RW'(ROWS - 1)) && (cur_col_reg == '0))
        else $error("scroll left the cursor off the start of the bottom line");

endmodule

/* bench/tb_text_console_engine.sv */
// Self-checking bench for the text console engine: queued commands, shadow screen, strobe checks.
`timescale 1ns / 1ps

module tb_text_console_engine;
    import tce_pkg::*;

    localparam int SCREEN_COLS   = DEFAULT_COLUMNS;
    localparam int SCREEN_ROWS   = DEFAULT_ROWS;
    localparam int SCREEN_CELLS  = SCREEN_ROWS * SCREEN_COLS;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 60;
    localparam longint TIMEOUT_NS = 64'd100_000_000;

    // Indexes past the register list; the block must ignore them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    command_t              command;
    logic                  done;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the console state.
    logic [CELL_W-1:0] shadow_cells [0:SCREEN_CELLS-1];
    int unsigned       shadow_row;
    int unsigned       shadow_col;
    logic [7:0]        shadow_attr;
    logic              shadow_enable;

    command_t    pending_cmds[$];
    result_t     awaited_results[$];
    logic        word_taken;
    int unsigned send_idle_pct;
    int unsigned error_count;
    int unsigned results_checked;
    int unsigned scrolls_seen;
    int unsigned rejects_seen;
    int unsigned clears_seen;
    int unsigned reads_seen;

    text_console_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {shadow_attr, BLANK_CHAR};
    endfunction

    // Move to column 0 of the next row; scroll when past the bottom.
    function automatic bit line_advance();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row < SCREEN_ROWS)
            return 1'b0;
        for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
            shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
        for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_CELLS; i++)
            shadow_cells[i] = blank_cell();
        shadow_row = SCREEN_ROWS - 1;
        return 1'b1;
    endfunction

    function automatic bit put_byte(logic [7:0] ch);
        bit wrapped;
        wrapped = 1'b0;
        if (ch == CHAR_NEWLINE)
            wrapped = line_advance();
        else if (ch == CHAR_RETURN)
            shadow_col = 0;
        else if (ch == CHAR_TAB)
        begin
            shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
            if (shadow_col >= SCREEN_COLS)
                wrapped = line_advance();
        end
        else if (ch == CHAR_BACKSPACE)
        begin
            if (shadow_col > 0)
            begin
                shadow_col--;
                shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = blank_cell();
            end
            else if (shadow_row > 0)
            begin
                shadow_row--;
                shadow_col = SCREEN_COLS - 1;
                shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = blank_cell();
            end
        end
        else if (ch >= CHAR_PRINT_LO && ch <= CHAR_PRINT_HI)
        begin
            shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = {shadow_attr, ch};
            shadow_col++;
            if (shadow_col >= SCREEN_COLS)
                wrapped = line_advance();
        end
        return wrapped;
    endfunction

    // Apply one command to the shadow state and give the result word it should produce.
    function automatic result_t console_apply(command_t c);
        result_t       r;
        logic          report;
        logic          scr;
        logic          rej;
        logic [CELL_W-1:0] cell_word;
        bit            in_range;
        report    = 1'b0;
        scr       = 1'b0;
        rej       = 1'b0;
        cell_word = '0;
        in_range  = (c.target_row < SCREEN_ROWS) && (c.target_col < SCREEN_COLS);
        case (c.cmd)
            CMD_PUT:
            begin
                scr    = put_byte(c.char_code);
                report = 1'b1;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SCREEN_CELLS; i++)
                    shadow_cells[i] = blank_cell();
                shadow_row = 0;
                shadow_col = 0;
                report     = 1'b1;
            end
            CMD_SET:
            begin
                if (in_range)
                begin
                    shadow_row = 32'(c.target_row);
                    shadow_col = 32'(c.target_col);
                    report     = 1'b1;
                end
                else
                    rej = 1'b1;
            end
            default:
            begin
                if (in_range)
                    cell_word = shadow_cells[c.target_row * SCREEN_COLS + c.target_col];
                else
                    rej = 1'b1;
            end
        endcase
        r.cursor_row_out  = 5'(shadow_row);
        r.cursor_col_out  = 7'(shadow_col);
        r.cursor_position = 11'(shadow_row * SCREEN_COLS + shadow_col);
        r.cursor_update   = report & shadow_enable;
        r.cell_value      = cell_word;
        r.rejected        = rej;
        r.scrolled        = scr;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
                     $realtime, results_checked, what, got, want);
    endtask

    // Drive: hold the word until taken, then offer the next one or idle.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || word_taken)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    command <= pending_cmds.pop_front();
                    start   <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Check strobed results, then predict for a word taken at this edge.
    always @(posedge clk)
    begin : monitor
        result_t want;
        word_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with none awaited", 32'(result), 32'h0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.cursor_row_out !== want.cursor_row_out)
                        report_mismatch("cursor_row_out", 32'(result.cursor_row_out),
                                        32'(want.cursor_row_out));
                    if (result.cursor_col_out !== want.cursor_col_out)
                        report_mismatch("cursor_col_out", 32'(result.cursor_col_out),
                                        32'(want.cursor_col_out));
                    if (result.cursor_position !== want.cursor_position)
                        report_mismatch("cursor_position", 32'(result.cursor_position),
                                        32'(want.cursor_position));
                    if (result.cursor_update !== want.cursor_update)
                        report_mismatch("cursor_update", 32'(result.cursor_update),
                                        32'(want.cursor_update));
                    if (result.cell_value !== want.cell_value)
                        report_mismatch("cell_value", 32'(result.cell_value),
                                        32'(want.cell_value));
                    if (result.rejected !== want.rejected)
                        report_mismatch("rejected", 32'(result.rejected), 32'(want.rejected));
                    if (result.scrolled !== want.scrolled)
                        report_mismatch("scrolled", 32'(result.scrolled), 32'(want.scrolled));
                    results_checked++;
                    if (want.scrolled)
                        scrolls_seen++;
                    if (want.rejected)
                        rejects_seen++;
                end
            end
            if (start && !busy)
            begin
                if (command.cmd == CMD_CLEAR)
                    clears_seen++;
                if (command.cmd == CMD_READ)
                    reads_seen++;
                awaited_results.push_back(console_apply(command));
            end
        end
    end

    function automatic command_t make_cmd(cmd_code_t op, logic [7:0] ch,
                                          logic [7:0] row, logic [7:0] col);
        command_t c;
        c.cmd        = op;
        c.char_code  = ch;
        c.target_row = row;
        c.target_col = col;
        return c;
    endfunction

    function automatic logic [7:0] random_char();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return 8'($urandom_range(CHAR_PRINT_HI, CHAR_PRINT_LO));
        else if (pick < 58)
            return CHAR_NEWLINE;
        else if (pick < 63)
            return CHAR_RETURN;
        else if (pick < 71)
            return CHAR_TAB;
        else if (pick < 81)
            return CHAR_BACKSPACE;
        else if (pick < 90)
            return 8'($urandom_range(31));
        return 8'($urandom_range(255, 128));
    endfunction

    // Fill the target fields: edges of the screen often, out of range now and then.
    function automatic command_t aim(command_t c, int unsigned miss_pct);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < miss_pct)
        begin
            case ($urandom_range(2))
                0: c.target_row = 8'($urandom_range(255, SCREEN_ROWS));
                1: c.target_col = 8'($urandom_range(255, SCREEN_COLS));
                default:
                begin
                    c.target_row = 8'($urandom_range(255, SCREEN_ROWS));
                    c.target_col = 8'($urandom_range(255, SCREEN_COLS));
                end
            endcase
            return c;
        end
        case ($urandom_range(3))
            0: c.target_row = 8'h00;
            1: c.target_row = 8'(SCREEN_ROWS - 1);
            default: c.target_row = 8'($urandom_range(SCREEN_ROWS - 1));
        endcase
        case ($urandom_range(4))
            0: c.target_col = 8'h00;
            1: c.target_col = 8'(SCREEN_COLS - 1);
            2: c.target_col = 8'($urandom_range(SCREEN_COLS - 1, SCREEN_COLS - TAB_STEP));
            default: c.target_col = 8'($urandom_range(SCREEN_COLS - 1));
        endcase
        return c;
    endfunction

    function automatic command_t random_command();
        command_t    c;
        int unsigned pick;
        c.cmd        = CMD_PUT;
        c.char_code  = 8'($urandom_range(255));
        c.target_row = 8'($urandom_range(255));
        c.target_col = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 60)
            c.char_code = random_char();
        else if (pick < 62)
            c.cmd = CMD_CLEAR;
        else if (pick < 80)
        begin
            c.cmd = CMD_SET;
            c = aim(c, 25);
        end
        else
        begin
            c.cmd = CMD_READ;
            c = aim(c, 20);
        end
        return c;
    endfunction

    task automatic drain_console();
        while (pending_cmds.size() != 0 || start || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TEXT_ATTRIBUTE)
            shadow_attr = val;
        else if (idx == REG_CURSOR_ENABLE)
            shadow_enable = val[0];
    endtask

    task automatic run_random(int unsigned count, int unsigned idle);
        send_idle_pct = idle;
        for (int n = 0; n < count; n++)
            pending_cmds.push_back(random_command());
        drain_console();
    endtask

    task automatic load_directed();
        pending_cmds.push_back(make_cmd(CMD_READ, 8'hFF, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 8'(SCREEN_ROWS - 1),
                                        8'(SCREEN_COLS - 1)));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_PRINT_LO, 8'hFF, 8'hFF));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_PRINT_HI, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, 8'h41, 8'hAA, 8'h55));
        pending_cmds.push_back(make_cmd(CMD_PUT, 8'h80, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, 8'hFF, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_TAB, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_RETURN, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_NEWLINE, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 8'h00, 8'h02));
        // Backspace at the top-left corner, then across a line start.
        pending_cmds.push_back(make_cmd(CMD_SET, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_BACKSPACE, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_SET, 8'h00, 8'h01, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_BACKSPACE, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, 8'h5A, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_SET, 8'h00, 8'h00, 8'(SCREEN_COLS - 5)));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_TAB, 8'h00, 8'h00));
        // Line advance and wrap on the bottom row both scroll.
        pending_cmds.push_back(make_cmd(CMD_SET, 8'h00, 8'(SCREEN_ROWS - 1), 8'h00));
        pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_NEWLINE, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_SET, 8'h00, 8'(SCREEN_ROWS - 1),
                                        8'(SCREEN_COLS - 1)));
        pending_cmds.push_back(make_cmd(CMD_PUT, 8'h78, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_SET, 8'h00, 8'(SCREEN_ROWS), 8'h00));
        pending_cmds.push_back(make_cmd(CMD_SET, 8'h00, 8'h00, 8'(SCREEN_COLS)));
        pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 8'hFF, 8'hFF));
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 8'(SCREEN_ROWS - 1), 8'h00));
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_text_console_engine: done, errors");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        word_taken    = 1'b0;
        send_idle_pct = 0;
        error_count   = 0;
        results_checked = 0;
        scrolls_seen  = 0;
        rejects_seen  = 0;
        clears_seen   = 0;
        reads_seen    = 0;
        shadow_attr   = ATTR_RESET;
        shadow_enable = 1'b1;
        shadow_row    = 0;
        shadow_col    = 0;
        for (int i = 0; i < SCREEN_CELLS; i++)
            shadow_cells[i] = RESET_CELL;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_directed();
        drain_console();

        write_register(REG_TEXT_ATTRIBUTE, 8'hFF);
        write_register(REG_SPARE_LO, 8'($urandom_range(255)));
        run_random(200, 0);

        write_register(REG_TEXT_ATTRIBUTE, 8'h00);
        write_register(REG_CURSOR_ENABLE, 8'h00);
        // Drain half-way through so that all awaited results come back before the second half.
        run_random(100, 46);
        run_random(100, 46);

        write_register(REG_TEXT_ATTRIBUTE, 8'($urandom_range(255)));
        write_register(REG_CURSOR_ENABLE, 8'h01);
        write_register(REG_SPARE_HI, 8'($urandom_range(255)));
        run_random(200, 0);

        write_register(REG_TEXT_ATTRIBUTE, 8'($urandom_range(255)));
        write_register(REG_CURSOR_ENABLE, 8'hFF);
        run_random(200, 33);

        $display("covered %0d commands: %0d scrolls, %0d clears, %0d reads, %0d rejected",
                 results_checked, scrolls_seen, clears_seen, reads_seen, rejects_seen);
        $display("five phases with sender gaps of 0, 46 and 33 percent; %0d mismatches",
                 error_count);
        if (error_count == 0)
            $display("tb_text_console_engine: done, clean");
        else
            $display("tb_text_console_engine: done, errors");
        $finish;
    end

endmodule
